// ===== hw/rtl/csppu_pkg.sv =====
// Package: shared types, constants and helper functions of the prefetch predictor.
`timescale 1ns / 1ps

package csppu_pkg;

  localparam int unsigned TableEntriesDef = 64;
  localparam logic [31:0] LastReset       = 32'd5;

  localparam logic [4:0] OffBitsReset = 5'd6;
  localparam logic [4:0] SetBitsReset = 5'd6;

  typedef enum logic [1:0] {
    CFG_LINE_OFFSET = 2'd0,
    CFG_SET_INDEX   = 2'd1,
    CFG_FALLBACK    = 2'd2
  } csppu_cfg_e;

  typedef enum logic [1:0] {
    KIND_CORR   = 2'd0,
    KIND_STRIDE = 2'd1,
    KIND_NEXT   = 2'd2
  } csppu_kind_e;

  typedef enum logic [1:0] {
    CONF_INIT   = 2'd0,
    CONF_TRANS  = 2'd1,
    CONF_STEADY = 2'd2,
    CONF_NONE   = 2'd3
  } csppu_conf_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD,
    ST_PRI,
    ST_CAND,
    ST_EMIT
  } csppu_state_e;

  typedef struct packed {
    logic cap_hit;
    logic cap_prior;
    logic ins;
    logic upd;
  } csppu_cell_ctrl_t;

  function automatic logic [1:0] next_conf(input logic [1:0] c, input logic ok);
    logic [1:0] r;
    if (ok) begin
      r = (c == CONF_NONE) ? CONF_TRANS : CONF_STEADY;
    end else begin
      case (c)
        CONF_INIT:   r = CONF_TRANS;
        CONF_TRANS:  r = CONF_NONE;
        CONF_STEADY: r = CONF_INIT;
        default:     r = CONF_NONE;
      endcase
    end
    return r;
  endfunction

  function automatic logic [31:0] block_of(input logic [31:0] a, input logic [4:0] ob);
    logic [32:0] low;
    low = (33'd1 << ob) - 33'd1;
    return a & ~low[31:0];
  endfunction

  function automatic logic [31:0] next_line(input logic [31:0] a, input logic [4:0] ob,
                                            input logic [4:0] ib);
    logic [63:0] mask;
    logic [63:0] idx;
    logic [63:0] tag;
    logic [5:0]  sh;
    logic [63:0] res;
    mask = (64'd1 << ib) - 64'd1;
    sh   = {1'b0, ob} + {1'b0, ib};
    idx  = ({32'd0, a} >> ob) & mask;
    tag  = {32'd0, a} >> sh;
    if (idx < mask) begin
      idx = idx + 64'd1;
    end else begin
      idx = 64'd0;
      tag = tag + 64'd1;
    end
    res = (tag << sh) | (idx << ob);
    return res[31:0];
  endfunction

endpackage

// ===== hw/rtl/csppu_cell.sv =====
// One correlation table entry: storage, local compares and in-place update.
`timescale 1ns / 1ps

module csppu_cell
  import csppu_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  csppu_cell_ctrl_t ctrl_i,
  input  logic [31:0]      key_i,
  input  logic [31:0]      last_i,
  output logic             hit_o,
  output logic             prior_hit_o,
  output logic [31:0]      block_o,
  output logic [1:0]       conf_o
);

  logic        valid_q;
  logic        hit_q;
  logic        prior_hit_q;
  logic [31:0] block_q;
  logic [31:0] prior_q;
  logic [1:0]  conf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      hit_q       <= 1'b0;
      prior_hit_q <= 1'b0;
    end else begin
      if (ctrl_i.cap_hit) begin
        hit_q <= valid_q && (block_q == key_i);
      end
      if (ctrl_i.cap_prior) begin
        prior_hit_q <= valid_q && (prior_q == key_i);
      end
      if (ctrl_i.ins) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins) begin
      block_q <= key_i;
      prior_q <= last_i;
      conf_q  <= CONF_INIT;
    end else if (ctrl_i.upd) begin
      prior_q <= last_i;
      conf_q  <= next_conf(conf_q, prior_q == last_i);
    end
  end

  assign hit_o       = hit_q;
  assign prior_hit_o = prior_hit_q;
  assign block_o     = block_q;
  assign conf_o      = conf_q;

endmodule

// ===== hw/rtl/correlation_stride_prefetch_predictor_unit.sv =====
// Top level: correlation/stride prefetch predictor built on a row of table cells.
`timescale 1ns / 1ps

// One access is taken when start_i is high and busy_o low. The access occupies
// the block through the table-work states (match compare, entry update, predecessor
// compare, candidate selection) and then through one emit state per candidate.
// Candidates appear one per cycle on valid_o with no backpressure; the receiver
// must take every beat. last_candidate_o marks the final beat of an access.
// Configuration writes are always accepted and must arrive only while idle.
module correlation_stride_prefetch_predictor_unit
  import csppu_pkg::*;
#(
  parameter int unsigned TableEntries = TableEntriesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] access_address_i,
  output logic        valid_o,
  output logic [31:0] candidate_address_o,
  output logic [1:0]  candidate_kind_o,
  output logic        last_candidate_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [4:0]  cfg_data_i
);

  localparam int unsigned IdxW = $clog2(TableEntries);

  csppu_state_e state_q, state_d;

  logic [4:0]      off_bits_q, set_bits_q;
  logic            fallback_q;
  logic [31:0]     b_q, l_q, last_q, stride_q;
  logic [1:0]      sconf_q;
  logic [IdxW-1:0] ptr_q;

  logic [31:0] cand_addr_q [3];
  logic [1:0]  cand_kind_q [3];
  logic [31:0] cand_addr_d [3];
  logic [1:0]  cand_kind_d [3];
  logic [1:0]  cand_cnt_q, cand_cnt_d;
  logic [1:0]  emit_q;

  logic [TableEntries-1:0] hit_vec, pri_vec, hit_first, pri_first;
  logic [31:0]             cell_block [TableEntries];
  logic [1:0]              cell_conf [TableEntries];
  csppu_cell_ctrl_t        cell_ctrl [TableEntries];
  logic                    any_hit, any_pri;
  logic [31:0]             corr_block;
  logic [1:0]              corr_conf;
  logic                    neq;

  assign cfg_ready_o = 1'b1;
  assign neq         = (b_q != l_q);
  assign hit_first   = hit_vec & (~hit_vec + TableEntries'(1));
  assign pri_first   = pri_vec & (~pri_vec + TableEntries'(1));
  assign any_hit     = |hit_vec;
  assign any_pri     = |pri_vec;

  for (genvar g = 0; g < TableEntries; g++) begin : g_cell
    always_comb begin
      cell_ctrl[g].cap_hit   = (state_q == ST_CMP);
      cell_ctrl[g].cap_prior = (state_q == ST_PRI);
      cell_ctrl[g].ins       = (state_q == ST_UPD) && !any_hit && (ptr_q == IdxW'(g));
      cell_ctrl[g].upd       = (state_q == ST_UPD) && hit_first[g] && neq;
    end
    csppu_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cell_ctrl[g]),
      .key_i       (b_q),
      .last_i      (l_q),
      .hit_o       (hit_vec[g]),
      .prior_hit_o (pri_vec[g]),
      .block_o     (cell_block[g]),
      .conf_o      (cell_conf[g])
    );
  end

  always_comb begin
    corr_block = '0;
    corr_conf  = '0;
    for (int i = 0; i < TableEntries; i++) begin
      corr_block = corr_block | (cell_block[i] & {32{pri_first[i]}});
      corr_conf  = corr_conf | (cell_conf[i] & {2{pri_first[i]}});
    end
  end

  always_comb begin
    logic [1:0]  n;
    logic [31:0] mag;
    n   = 2'd0;
    mag = 32'd0 - stride_q;
    for (int k = 0; k < 3; k++) begin
      cand_addr_d[k] = cand_addr_q[k];
      cand_kind_d[k] = cand_kind_q[k];
    end
    if (any_pri && corr_conf != CONF_NONE) begin
      cand_addr_d[n] = corr_block;
      cand_kind_d[n] = KIND_CORR;
      n = n + 2'd1;
    end
    if (neq && (sconf_q == CONF_TRANS || sconf_q == CONF_STEADY)) begin
      if (stride_q != 32'd0 && !stride_q[31]) begin
        cand_addr_d[n] = b_q + stride_q;
        cand_kind_d[n] = KIND_STRIDE;
        n = n + 2'd1;
      end else if (mag <= b_q) begin
        cand_addr_d[n] = b_q - mag;
        cand_kind_d[n] = KIND_STRIDE;
        n = n + 2'd1;
      end
    end
    if (fallback_q) begin
      cand_addr_d[n] = next_line(b_q, off_bits_q, set_bits_q);
      cand_kind_d[n] = KIND_NEXT;
      n = n + 2'd1;
    end
    cand_cnt_d = n;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (start_i) state_d = ST_CMP;
      ST_CMP:  state_d = ST_UPD;
      ST_UPD:  state_d = ST_PRI;
      ST_PRI:  state_d = ST_CAND;
      ST_CAND: state_d = (cand_cnt_d == 2'd0) ? ST_IDLE : ST_EMIT;
      ST_EMIT: if (emit_q == cand_cnt_q - 2'd1) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy_o              = (state_q != ST_IDLE);
    valid_o             = (state_q == ST_EMIT);
    candidate_address_o = cand_addr_q[emit_q];
    candidate_kind_o    = cand_kind_q[emit_q];
    last_candidate_o    = (emit_q == cand_cnt_q - 2'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      off_bits_q <= OffBitsReset;
      set_bits_q <= SetBitsReset;
      fallback_q <= 1'b1;
      last_q     <= LastReset;
      stride_q   <= '0;
      sconf_q    <= CONF_INIT;
      ptr_q      <= '0;
      cand_cnt_q <= '0;
      emit_q     <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_LINE_OFFSET: off_bits_q <= cfg_data_i;
          CFG_SET_INDEX:   set_bits_q <= cfg_data_i;
          CFG_FALLBACK:    fallback_q <= cfg_data_i[0];
          default:         ;
        endcase
      end
      if (state_q == ST_UPD) begin
        if (!any_hit) begin
          ptr_q <= (ptr_q == IdxW'(TableEntries - 1)) ? '0 : ptr_q + IdxW'(1);
        end
        if (neq) begin
          if ((b_q - l_q) != stride_q) stride_q <= b_q - l_q;
          sconf_q <= next_conf(sconf_q, (b_q - l_q) == stride_q);
        end
        last_q <= b_q;
      end
      if (state_q == ST_CAND) begin
        cand_cnt_q <= cand_cnt_d;
        emit_q     <= '0;
      end else if (state_q == ST_EMIT) begin
        emit_q <= emit_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      b_q <= block_of(access_address_i, off_bits_q);
      l_q <= last_q;
    end
    if (state_q == ST_CAND) begin
      for (int k = 0; k < 3; k++) begin
        cand_addr_q[k] <= cand_addr_d[k];
        cand_kind_q[k] <= cand_kind_d[k];
      end
    end
  end

endmodule

// ===== hw/rtl/csppu_checker.sv =====
// Port-level checker for the prefetch predictor, bound to the top level.
`timescale 1ns / 1ps

module csppu_checker
  import csppu_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       valid_o,
  input logic [1:0] candidate_kind_o,
  input logic       last_candidate_o
);

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("access not taken");

  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy_o) else $error("beat outside an access");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> candidate_kind_o != 2'd3) else $error("bad kind");

  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_candidate_o |=> valid_o) else $error("burst broken");

  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_candidate_o |=> !valid_o && !busy_o) else $error("burst overrun");

endmodule

bind correlation_stride_prefetch_predictor_unit csppu_checker u_csppu_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start_i          (start_i),
  .busy_o           (busy_o),
  .valid_o          (valid_o),
  .candidate_kind_o (candidate_kind_o),
  .last_candidate_o (last_candidate_o)
);
